>>> sv/fbpa_pkg.sv
// Package of the fixed block pool allocator: types, codes and fixed field widths.
package fbpa_pkg;

	// Fixed widths of the register and item fields.
	localparam int ADDR_FIELD_W  = 32;
	localparam int SIZE_FIELD_W  = 16;
	localparam int COUNT_FIELD_W = 8;
	localparam int INDEX_FIELD_W = 8;
	localparam int FREE_FIELD_W  = 8;
	localparam int STATUS_W      = 3;
	localparam int REG_INDEX_W   = 2;

	// Effective unit size, rounded up to a multiple of four, needs one bit more.
	localparam int SIZE_W = SIZE_FIELD_W + 1;

	// Configuration register indexes.
	localparam logic [REG_INDEX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [REG_INDEX_W-1:0] REG_SIZE  = 2'd1;
	localparam logic [REG_INDEX_W-1:0] REG_COUNT = 2'd2;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 3'd0,
		STAT_EMPTY      = 3'd1,
		STAT_MISALIGNED = 3'd2,
		STAT_RANGE      = 3'd3,
		STAT_NOT_USED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_ALLOC,
		S_DIV,
		S_CHECK,
		S_FREE
	} state_t;

endpackage

>>> sv/fbpa_divider.sv
// Iterative restoring divider of a pool offset by the effective unit size.
module fbpa_divider
	import fbpa_pkg::*;
#(
	parameter int DW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [DW-1:0]     quotient,
	output logic [SIZE_W-1:0] remainder
);

	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0]   count_q;
	logic              done_q;
	logic [DW-1:0]     quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W:0]   trial;
	logic              fits;

	// The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				count_q <= CNTW'(DW);
			end else if (count_q != '0) begin
				count_q <= count_q - 1'b1;
				if (count_q == CNTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (count_q != '0) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> sv/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: free queue, used map and request sequencer.
//
// The block hands out and takes back equal-sized units of a pool. A request beat is
// taken at a rising edge with start high and busy low: kind selects allocate or free,
// release_address names the unit to free. Unless a unit_count write cuts it short, each
// request yields exactly one result beat, shown for one cycle with done high:
// unit_address, unit_index, status and free_units. The receiver cannot hold results off;
// the block may take the next request in the very cycle a result is shown, since results
// sit in their own output registers. An allocate on an empty pool is answered straight
// from idle; any other allocate takes a free queue read, then the used-map write and the
// address multiply-add. A free first runs the one-bit-per-cycle divider that turns the
// offset into an index, ends there when it fails alignment or range, and otherwise goes
// on to the used-map read. One request is in flight at a time. Configuration registers
// are written through wr_en, wr_index and wr_data at any edge. After reset, and after
// every write of unit_count, the block sweeps every entry of both memories, refilling
// the free queue in index order and clearing the used map; busy is high during the
// sweep. Base address and unit size writes touch nothing else.
module fixed_block_pool_allocator_top
	import fbpa_pkg::*;
#(
	parameter int MAX_UNITS     = 256,
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     kind,
	input  logic [ADDR_FIELD_W-1:0]  release_address,
	output logic                     done,
	output logic [ADDR_FIELD_W-1:0]  unit_address,
	output logic [INDEX_FIELD_W-1:0] unit_index,
	output logic [STATUS_W-1:0]      status,
	output logic [FREE_FIELD_W-1:0]  free_units,
	input  logic                     wr_en,
	input  logic [REG_INDEX_W-1:0]   wr_index,
	input  logic [ADDR_FIELD_W-1:0]  wr_data
);

	localparam int AW = ADDRESS_WIDTH;
	localparam int IW = $clog2(MAX_UNITS);
	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam int SW = CW + 1;
	localparam int PW = SIZE_W + IW;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_UNITS - 1);
	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_UNITS);

	// Configuration registers.
	logic [ADDR_FIELD_W-1:0]  base_q;
	logic [SIZE_FIELD_W-1:0]  size_q;
	logic [COUNT_FIELD_W-1:0] count_q;

	// Sequencer and queue pointers.
	state_t        state_q, state_d;
	logic [IW-1:0] sweep_q, sweep_d;
	logic [IW-1:0] head_q, head_d;
	logic [IW-1:0] tail_q, tail_d;
	logic [CW-1:0] fill_q, fill_d;

	// Result registers.
	logic                     done_q, done_d;
	logic [ADDR_FIELD_W-1:0]  addr_q, addr_d;
	logic [INDEX_FIELD_W-1:0] index_q, index_d;
	status_t                  status_q, status_d;
	logic [FREE_FIELD_W-1:0]  free_q, free_d;

	// Memories and their ports.
	logic [IW-1:0] queue_mem [MAX_UNITS];
	logic          used_mem  [MAX_UNITS];
	logic          q_we, m_we, m_wdata;
	logic [IW-1:0] q_waddr, q_wdata, m_waddr;
	logic [IW-1:0] q_rdata_q;
	logic          m_rdata_q;

	// Divider.
	logic              div_start, div_done;
	logic [AW-1:0]     offset, quotient;
	logic [SIZE_W-1:0] remainder;
	logic [IW-1:0]     quo_idx;

	// Derived values.
	logic [SIZE_W-1:0] size_eff;
	logic [CW-1:0]     n_units, n_new;
	logic [PW-1:0]     product;
	logic [AW-1:0]     alloc_addr;
	logic              count_wr;

	// Clamp of a unit count to the capacity of the pool.
	function automatic logic [CW-1:0] clamp_count(input logic [COUNT_FIELD_W-1:0] c);
		logic [COUNT_FIELD_W:0] ext;
		ext = (COUNT_FIELD_W + 1)'(c);
		if (ext > (COUNT_FIELD_W + 1)'(MAX_UNITS)) begin
			return MAX_CNT;
		end
		return CW'(c);
	endfunction

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
		return (p == LAST_IDX) ? '0 : IW'(p + 1'b1);
	endfunction

	// Sizes of zero to three are taken as four; others round up to a multiple of four.
	assign size_eff = (size_q == '0) ? SIZE_W'(4)
	                                 : ((SIZE_W'(size_q) + SIZE_W'(3)) & ~SIZE_W'(3));
	assign n_units  = clamp_count(count_q);
	assign n_new    = clamp_count(wr_data[COUNT_FIELD_W-1:0]);
	assign count_wr = wr_en && (wr_index == REG_COUNT);

	assign offset     = AW'(release_address) - AW'(base_q);
	assign quo_idx    = quotient[IW-1:0];
	assign product    = PW'(size_eff) * PW'(q_rdata_q);
	assign alloc_addr = AW'(base_q) + AW'(product);

	fbpa_divider #(
		.DW(AW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (offset),
		.divisor  (size_eff),
		.done     (div_done),
		.quotient (quotient),
		.remainder(remainder)
	);

	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		head_d    = head_q;
		tail_d    = tail_q;
		fill_d    = fill_q;
		done_d    = 1'b0;
		addr_d    = addr_q;
		index_d   = index_q;
		status_d  = status_q;
		free_d    = free_q;
		q_we      = 1'b0;
		q_waddr   = tail_q;
		q_wdata   = quo_idx;
		m_we      = 1'b0;
		m_waddr   = quo_idx;
		m_wdata   = 1'b0;
		div_start = 1'b0;

		unique case (state_q)
			S_SWEEP: begin
				// Queue entry i holds index i; no unit is marked as handed out.
				q_we    = 1'b1;
				q_waddr = sweep_q;
				q_wdata = sweep_q;
				m_we    = 1'b1;
				m_waddr = sweep_q;
				m_wdata = 1'b0;
				sweep_d = wrap_inc(sweep_q);
				if (sweep_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_FREE) begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end else if (fill_q == '0) begin
						done_d   = 1'b1;
						addr_d   = '0;
						index_d  = '0;
						status_d = STAT_EMPTY;
						free_d   = FREE_FIELD_W'(fill_q);
					end else begin
						state_d = S_ALLOC;
					end
				end
			end
			S_ALLOC: begin
				// The head entry was read at the accepting edge.
				m_we     = 1'b1;
				m_waddr  = q_rdata_q;
				m_wdata  = 1'b1;
				head_d   = wrap_inc(head_q);
				fill_d   = fill_q - 1'b1;
				done_d   = 1'b1;
				addr_d   = ADDR_FIELD_W'(alloc_addr);
				index_d  = INDEX_FIELD_W'(q_rdata_q);
				status_d = STAT_OK;
				free_d   = FREE_FIELD_W'(fill_q - 1'b1);
				state_d  = S_IDLE;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				addr_d  = '0;
				index_d = '0;
				free_d  = FREE_FIELD_W'(fill_q);
				priority if (remainder != '0) begin
					done_d   = 1'b1;
					status_d = STAT_MISALIGNED;
					state_d  = S_IDLE;
				end else if (quotient >= AW'(n_units)) begin
					done_d   = 1'b1;
					status_d = STAT_RANGE;
					state_d  = S_IDLE;
				end else begin
					// The used-map entry of the quotient is read at this edge.
					state_d = S_FREE;
				end
			end
			S_FREE: begin
				done_d  = 1'b1;
				addr_d  = '0;
				state_d = S_IDLE;
				if (!m_rdata_q) begin
					index_d  = '0;
					status_d = STAT_NOT_USED;
					free_d   = FREE_FIELD_W'(fill_q);
				end else begin
					m_we     = 1'b1;
					m_waddr  = quo_idx;
					m_wdata  = 1'b0;
					q_we     = 1'b1;
					q_waddr  = tail_q;
					q_wdata  = quo_idx;
					tail_d   = wrap_inc(tail_q);
					fill_d   = fill_q + 1'b1;
					index_d  = INDEX_FIELD_W'(quo_idx);
					status_d = STAT_OK;
					free_d   = FREE_FIELD_W'(fill_q + 1'b1);
				end
			end
			default: begin
				state_d = S_SWEEP;
				sweep_d = '0;
			end
		endcase

		// A unit count write re-creates the pool and restarts the sweep.
		if (count_wr) begin
			state_d = S_SWEEP;
			sweep_d = '0;
			head_d  = '0;
			tail_d  = (n_new == MAX_CNT) ? '0 : IW'(n_new);
			fill_d  = n_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
			base_q  <= '0;
			size_q  <= SIZE_FIELD_W'(4);
			count_q <= '0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
			if (wr_en) begin
				unique case (wr_index)
					REG_BASE:  base_q  <= wr_data;
					REG_SIZE:  size_q  <= wr_data[SIZE_FIELD_W-1:0];
					REG_COUNT: count_q <= wr_data[COUNT_FIELD_W-1:0];
					default:   ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q   <= addr_d;
		index_q  <= index_d;
		status_q <= status_d;
		free_q   <= free_d;
	end

	// Free queue: one write port, one registered read port at the head.
	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		q_rdata_q <= queue_mem[head_q];
	end

	// Used map: one write port, one registered read port at the divider's quotient.
	always_ff @(posedge clk) begin
		if (m_we) begin
			used_mem[m_waddr] <= m_wdata;
		end
		m_rdata_q <= used_mem[quo_idx];
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign unit_address = addr_q;
	assign unit_index   = index_q;
	assign status       = status_q;
	assign free_units   = free_q;

	// Head plus fill, taken round the queue, must land on the tail.
	logic [SW-1:0] wrap_sum, wrap_pos;
	assign wrap_sum = SW'(head_q) + SW'(fill_q);
	assign wrap_pos = (wrap_sum >= SW'(MAX_UNITS)) ? SW'(wrap_sum - SW'(MAX_UNITS)) : wrap_sum;

	a_queue_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= MAX_CNT) && (IW'(wrap_pos) == tail_q))
		else $error("free queue pointers and fill count disagree");

	a_alloc_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) && !count_wr |=> done_q && (status_q == STAT_OK) && !busy)
		else $error("allocate did not deliver its result");

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != STAT_OK) |-> (unit_index == '0) && (unit_address == '0))
		else $error("failed request carries an index or address");

endmodule
